// ===== hdl/nprs_pkg.sv =====
// shared types, codes and constants for the nand page read sequencer
`timescale 1ns / 1ps

package nprs_pkg;

    // default configuration
    localparam int DEF_PAGE_BYTES = 2048;
    localparam int DEF_COUNT_BITS = 24;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int COUNT_W = 24;
    localparam int DEST_W = 24;
    localparam int BYTE_W = 8;

    // operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_READY = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;

    // nand command bytes
    localparam logic [BYTE_W-1:0] CMD_READ_SETUP = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READ_GO = 8'h30;

    // result actions
    typedef enum logic [2:0] {
        ACT_ENABLE = 3'd0,
        ACT_CMD = 3'd1,
        ACT_ADDR = 3'd2,
        ACT_DATA = 3'd3,
        ACT_DISABLE = 3'd4
    } action_t;

    // sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_READ = 3'b100
    } phase_t;

    // what follows the leading result of a run
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_DIS = 2'd1,
        TAIL_PAGE = 2'd2
    } tail_t;

    // one run of results, produced by one input item
    typedef struct packed {
        logic lead_data;              // 1 stored data first, 0 chip enable first
        tail_t tail;
        logic [BYTE_W-1:0] data;
        logic [DEST_W-1:0] offset;
        logic [ADDR_W-1:0] addr;      // flash address for the page run
    } run_desc_t;

    // index of the last result in a run
    function automatic logic [2:0] run_last_idx(input tail_t tail);
        logic [2:0] idx;
        unique case (tail)
            TAIL_NONE: idx = 3'd0;
            TAIL_DIS: idx = 3'd1;
            TAIL_PAGE: idx = 3'd7;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage

// ===== hdl/nprs_core.sv =====
// sequencer state and per-item run decision
`timescale 1ns / 1ps

module nprs_core
    import nprs_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         operation,
    input  logic [ADDR_W-1:0]  start_address,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic [BYTE_W-1:0]  flash_byte,
    output logic               desc_valid,
    output run_desc_t          desc
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    phase_t                phase_reg, phase_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [COUNT_BITS-1:0] offset_reg, offset_next;
    logic [ADDR_W-1:0]     addr_inc;
    logic [COUNT_BITS-1:0] left_dec;
    logic [COUNT_BITS-1:0] count_in;
    logic                  emit;

    assign addr_inc = addr_reg + ADDR_W'(1);
    assign left_dec = left_reg - COUNT_BITS'(1);
    assign count_in = COUNT_BITS'(byte_count);

    always_comb
    begin
        phase_next = phase_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        offset_next = offset_reg;
        emit = 1'b0;
        desc.lead_data = 1'b0;
        desc.tail = TAIL_NONE;
        desc.data = flash_byte;
        desc.offset = DEST_W'(offset_reg);
        desc.addr = addr_inc;
        unique case (operation)
            OP_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    emit = 1'b1;
                    addr_next = start_address;
                    left_next = count_in;
                    offset_next = '0;
                    desc.addr = start_address;
                    if (count_in == '0)
                    begin
                        desc.tail = TAIL_DIS;
                    end
                    else
                    begin
                        desc.tail = TAIL_PAGE;
                        phase_next = PH_WAIT;
                    end
                end
            end
            OP_READY:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    phase_next = PH_READ;
                end
            end
            OP_DATA:
            begin
                if (phase_reg == PH_READ)
                begin
                    emit = 1'b1;
                    desc.lead_data = 1'b1;
                    addr_next = addr_inc;
                    left_next = left_dec;
                    offset_next = offset_reg + COUNT_BITS'(1);
                    if (left_dec == '0)
                    begin
                        desc.tail = TAIL_DIS;
                        phase_next = PH_IDLE;
                    end
                    else if (addr_inc[PAGE_SHIFT-1:0] == '0)
                    begin
                        // page boundary crossed, next page needs a fresh read run
                        desc.tail = TAIL_PAGE;
                        phase_next = PH_WAIT;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign desc_valid = accept & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg <= '0;
            left_reg <= '0;
            offset_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            addr_reg <= addr_next;
            left_reg <= left_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== hdl/nprs_emit.sv =====
// run buffer and result emitter, one result per cycle while out_ready is high
`timescale 1ns / 1ps

module nprs_emit
    import nprs_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    input  run_desc_t         desc,
    output logic              desc_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        action,
    output logic [BYTE_W-1:0] bus_value,
    output logic [DEST_W-1:0] dest_offset,
    output logic              run_last
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] COL_MASK = ADDR_W'(PAGE_BYTES - 1);

    logic        pend_valid_reg, pend_valid_next;
    run_desc_t   pend_reg;
    logic        act_valid_reg, act_valid_next;
    run_desc_t   act_reg;
    logic [2:0]  idx_reg, idx_next;
    logic        out_fire;
    logic        is_last;
    logic        act_free;
    logic        load;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] page;
    action_t     act_code;

    assign out_fire = act_valid_reg & out_ready;
    assign is_last = (idx_reg == run_last_idx(act_reg.tail));
    assign act_free = ~act_valid_reg | (out_fire & is_last);
    assign load = pend_valid_reg & act_free;
    assign desc_ready = ~pend_valid_reg | load;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (desc_valid & desc_ready)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        act_valid_next = act_valid_reg;
        idx_next = idx_reg;
        if (load)
        begin
            act_valid_next = 1'b1;
            idx_next = '0;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                act_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg <= act_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_valid & desc_ready)
        begin
            pend_reg <= desc;
        end
        if (load)
        begin
            act_reg <= pend_reg;
        end
    end

    // column and page of the run address
    assign col = act_reg.addr & COL_MASK;
    assign page = act_reg.addr >> PAGE_SHIFT;

    always_comb
    begin
        act_code = ACT_ENABLE;
        bus_value = '0;
        dest_offset = '0;
        if (idx_reg == 3'd0)
        begin
            if (act_reg.lead_data)
            begin
                act_code = ACT_DATA;
                bus_value = act_reg.data;
                dest_offset = act_reg.offset;
            end
        end
        else if (act_reg.tail == TAIL_DIS)
        begin
            act_code = ACT_DISABLE;
        end
        else
        begin
            unique case (idx_reg)
                3'd1:
                begin
                    act_code = ACT_CMD;
                    bus_value = CMD_READ_SETUP;
                end
                3'd2:
                begin
                    act_code = ACT_ADDR;
                    bus_value = col[7:0];
                end
                3'd3:
                begin
                    act_code = ACT_ADDR;
                    bus_value = col[15:8];
                end
                3'd4:
                begin
                    act_code = ACT_ADDR;
                    bus_value = page[7:0];
                end
                3'd5:
                begin
                    act_code = ACT_ADDR;
                    bus_value = page[15:8];
                end
                3'd6:
                begin
                    act_code = ACT_ADDR;
                    bus_value = page[23:16];
                end
                default:
                begin
                    act_code = ACT_CMD;
                    bus_value = CMD_READ_GO;
                end
            endcase
        end
    end

    assign action = act_code;
    assign out_valid = act_valid_reg;
    assign run_last = is_last;

endmodule

// ===== hdl/nand_page_read_sequencer.sv =====
// top level of the large-page nand flash read sequencer
`timescale 1ns / 1ps

// large-page nand read sequencer. a start item (operation 0) raises chip
// enable and, for a nonzero byte count, emits the page read run: command
// 00h, column low and high, three page bytes, command 30h; a zero count
// gives enable then disable at once. a ready event (operation 1) moves the
// block from waiting to reading, and each data byte (operation 2) comes out
// as a stored data result with its destination offset. crossing a page
// boundary with bytes left emits a new page read run and waits for ready
// again; the last byte is followed by chip disable. events outside their
// phase and operation 3 are taken and dropped without results. one input
// item is taken per cycle while the buffer has room: phase and counters
// update in the cycle the item is taken, and its run (one to eight results,
// run_last on the final one) goes to a one-entry run buffer feeding the
// emitter, which sends one result per cycle while out_ready is high. input
// ready stays high as long as the buffer is empty or drains in that cycle,
// so single-result data items flow at one per cycle; a page read run holds
// the output for its eight results. PAGE_BYTES must be a power of two.

module nand_page_read_sequencer
    import nprs_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [ADDR_W-1:0]  start_address,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic [BYTE_W-1:0]  flash_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [BYTE_W-1:0]  bus_value,
    output logic [DEST_W-1:0]  dest_offset,
    output logic               run_last
);

    // run handoff between state logic and emitter
    logic      accept;
    logic      desc_valid;
    logic      desc_ready;
    run_desc_t desc;

    // every item is taken when the run buffer can take one, even if ignored
    assign in_ready = desc_ready;
    assign accept = in_valid & desc_ready;

    nprs_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (operation),
        .start_address (start_address),
        .byte_count    (byte_count),
        .flash_byte    (flash_byte),
        .desc_valid    (desc_valid),
        .desc          (desc)
    );

    nprs_emit #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .desc_ready  (desc_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .bus_value   (bus_value),
        .dest_offset (dest_offset),
        .run_last    (run_last)
    );

endmodule

// ===== verif/nprs_result_checker.sv =====
// result checker for the nand page read sequencer: predicts bus results and compares them
`timescale 1ns / 1ps

module nprs_result_checker
    import nprs_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [ADDR_W-1:0]  start_address,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic [BYTE_W-1:0]  flash_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         action,
    input  logic [BYTE_W-1:0]  bus_value,
    input  logic [DEST_W-1:0]  dest_offset,
    input  logic               run_last,
    output int                 fail_count,
    output int                 results_due,
    output int                 results_checked
);

    localparam logic [COUNT_W-1:0] CNT_MASK = COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

    typedef struct packed {
        action_t           act;
        logic [BYTE_W-1:0] value;
        logic [DEST_W-1:0] offset;
        logic              last;
    } bus_result_t;

    // own copy of the sequencer state
    phase_t             seq_phase;
    logic [ADDR_W-1:0]  next_addr;
    logic [COUNT_W-1:0] remaining;
    logic [DEST_W-1:0]  dest_cnt;

    bus_result_t due_results[$];
    bus_result_t got_item;

    function automatic bus_result_t bus_entry(input action_t a, input logic [BYTE_W-1:0] v,
                                              input logic [DEST_W-1:0] o);
        bus_result_t r;
        r.act = a;
        r.value = v;
        r.offset = o;
        r.last = 1'b0;
        return r;
    endfunction

    // entry idx of the page read run for flash address fa
    function automatic bus_result_t page_run_entry(input logic [ADDR_W-1:0] fa, input int idx);
        logic [31:0]       col;
        logic [31:0]       page;
        logic [BYTE_W-1:0] v;
        action_t           a;
        col = fa % 32'(PAGE_BYTES);
        page = fa / 32'(PAGE_BYTES);
        a = ACT_ADDR;
        case (idx)
            0: begin a = ACT_CMD; v = CMD_READ_SETUP; end
            1: v = col[7:0];
            2: v = col[15:8];
            3: v = page[7:0];
            4: v = page[15:8];
            5: v = page[23:16];
            default: begin a = ACT_CMD; v = CMD_READ_GO; end
        endcase
        return bus_entry(a, v, '0);
    endfunction

    task automatic derive_bus_results(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                      input logic [COUNT_W-1:0] cnt,
                                      input logic [BYTE_W-1:0] fbyte);
        bus_result_t run_buf [0:8];
        int          n;
        int          i;
        n = 0;
        case (op)
            OP_START:
                if (seq_phase == PH_IDLE) begin
                    next_addr = addr;
                    remaining = cnt & CNT_MASK;
                    dest_cnt = '0;
                    run_buf[n] = bus_entry(ACT_ENABLE, '0, '0);
                    n++;
                    if (remaining == '0) begin
                        run_buf[n] = bus_entry(ACT_DISABLE, '0, '0);
                        n++;
                    end else begin
                        for (i = 0; i < 7; i++) begin
                            run_buf[n] = page_run_entry(next_addr, i);
                            n++;
                        end
                        seq_phase = PH_WAIT;
                    end
                end
            OP_READY:
                if (seq_phase == PH_WAIT)
                    seq_phase = PH_READ;
            OP_DATA:
                if (seq_phase == PH_READ) begin
                    run_buf[n] = bus_entry(ACT_DATA, fbyte, dest_cnt);
                    n++;
                    dest_cnt = (dest_cnt + 1'b1) & CNT_MASK;
                    next_addr = next_addr + 1'b1;
                    remaining = (remaining - 1'b1) & CNT_MASK;
                    if (remaining == '0) begin
                        run_buf[n] = bus_entry(ACT_DISABLE, '0, '0);
                        n++;
                        seq_phase = PH_IDLE;
                    end else if ((next_addr % 32'(PAGE_BYTES)) == 0) begin
                        for (i = 0; i < 7; i++) begin
                            run_buf[n] = page_run_entry(next_addr, i);
                            n++;
                        end
                        seq_phase = PH_WAIT;
                    end
                end
            default: ;
        endcase
        if (n > 0)
            run_buf[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            due_results.push_back(run_buf[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seq_phase = PH_IDLE;
            next_addr = '0;
            remaining = '0;
            dest_cnt = '0;
            due_results.delete();
            fail_count = 0;
            results_checked = 0;
        end else begin
            // predict first so a result taken on the same edge still finds its item
            if (in_valid && in_ready)
                derive_bus_results(operation, start_address, byte_count, flash_byte);
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: action %0d bus_value %0h", action, bus_value);
                    fail_count++;
                end else begin
                    got_item = due_results.pop_front();
                    results_checked++;
                    if (action !== got_item.act) begin
                        $error("action mismatch: expected %0d, got %0d", got_item.act, action);
                        fail_count++;
                    end
                    if (bus_value !== got_item.value) begin
                        $error("bus_value mismatch: expected %0h, got %0h",
                               got_item.value, bus_value);
                        fail_count++;
                    end
                    if (dest_offset !== got_item.offset) begin
                        $error("dest_offset mismatch: expected %0h, got %0h",
                               got_item.offset, dest_offset);
                        fail_count++;
                    end
                    if (run_last !== got_item.last) begin
                        $error("run_last mismatch: expected %0b, got %0b",
                               got_item.last, run_last);
                        fail_count++;
                    end
                end
            end
        end
        results_due = due_results.size();
    end

endmodule

// ===== verif/nand_page_read_sequencer_tb.sv =====
// testbench top for the nand page read sequencer: stimulus, receiver and verdict
`timescale 1ns / 1ps

module nand_page_read_sequencer_tb;
    import nprs_pkg::*;

    // operation code the block has no use for
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PAGE = DEF_PAGE_BYTES;
    // input items to offer before the closing reads, directed ones included
    localparam int RANDOM_ITEMS = 360;
    // receiver hold-off used to fill the block and stall its input
    localparam int LONG_STALL = 300;
    // cycles with no item on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected result
    localparam int TAIL_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  start_address;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  flash_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         action;
    logic [BYTE_W-1:0]  bus_value;
    logic [DEST_W-1:0]  dest_offset;
    logic               run_last;

    int fail_count;
    int results_due;
    int results_checked;

    // stimulus bookkeeping
    int items_taken;
    int useful_items;
    int reads_started;
    int quiet_cycles;
    int seq_idx;

    // idling switches, read by the sender and the receiver
    bit in_idle_on;
    bit out_idle_on;

    // receiver hold-off requests and the ones it has served
    int stall_req_cnt;
    int stall_done_cnt;

    nand_page_read_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .start_address (start_address),
        .byte_count    (byte_count),
        .flash_byte    (flash_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .bus_value     (bus_value),
        .dest_offset   (dest_offset),
        .run_last      (run_last)
    );

    nprs_result_checker result_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .start_address   (start_address),
        .byte_count      (byte_count),
        .flash_byte      (flash_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .bus_value       (bus_value),
        .dest_offset     (dest_offset),
        .run_last        (run_last),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: counts cycles where neither channel moves an item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random back-pressure, plus a long hold-off when asked for
    initial
    begin
        out_ready = 1'b0;
        stall_done_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req_cnt != stall_done_cnt)
            begin
                // hold off long enough for the run buffer to fill and block input
                out_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
                stall_done_cnt++;
            end
            else if (out_idle_on && ($urandom_range(0, 99) < 37))
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // offer one item and hold it until taken; starts and ends at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [COUNT_W-1:0] cnt, input logic [BYTE_W-1:0] fbyte);
        if (in_idle_on)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        operation <= op;
        start_address <= addr;
        byte_count <= cnt;
        flash_byte <= fbyte;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_taken++;
        @(negedge clk);
    endtask

    // an item the block should drop in the given phase, random content
    task automatic send_noise(input phase_t ph);
        logic [1:0] op;
        int         pick;
        pick = $urandom_range(0, 2);
        case (ph)
            PH_IDLE: op = (pick == 0) ? OP_READY : (pick == 1) ? OP_DATA : OP_UNUSED;
            PH_WAIT: op = (pick == 0) ? OP_START : (pick == 1) ? OP_DATA : OP_UNUSED;
            default: op = (pick == 0) ? OP_START : (pick == 1) ? OP_READY : OP_UNUSED;
        endcase
        send_item(op, $urandom, COUNT_W'($urandom), BYTE_W'($urandom));
    endtask

    // sender pause until every predicted result has been seen
    task automatic wait_drain;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
    endtask

    // full read: start, then ready and data per page, with some dropped items mixed in
    task automatic read_sequence(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] cnt,
                                 input int noise_pct);
        logic [ADDR_W-1:0]  cur;
        logic [COUNT_W-1:0] left_bytes;
        if ($urandom_range(0, 99) < noise_pct)
            send_noise(PH_IDLE);
        send_item(OP_START, addr, cnt, BYTE_W'($urandom));
        useful_items++;
        reads_started++;
        cur = addr;
        left_bytes = cnt;
        while (left_bytes != 0)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(PH_WAIT);
            send_item(OP_READY, $urandom, COUNT_W'($urandom), BYTE_W'($urandom));
            useful_items++;
            do
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_noise(PH_READ);
                send_item(OP_DATA, $urandom, COUNT_W'($urandom), BYTE_W'($urandom));
                useful_items++;
                left_bytes--;
                cur++;
            end
            while (left_bytes != 0 && (cur % PAGE) != 0);
        end
    endtask

    // pick a random read: mostly short, often starting near a page edge or the top of flash
    task automatic random_read(input int noise_pct);
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        int                 pick;
        pick = $urandom_range(0, 9);
        addr = $urandom;
        if (pick == 9)
            addr = 32'hFFFF_FFFF - $urandom_range(0, 7);
        else if (pick >= 4)
            addr = (addr & ~32'(PAGE - 1)) + 32'(PAGE - $urandom_range(1, 8));
        if ($urandom_range(0, 9) < 7)
            cnt = COUNT_W'($urandom_range(0, 9));
        else
            cnt = COUNT_W'($urandom_range(10, 24));
        read_sequence(addr, cnt, noise_pct);
    endtask

    // main stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_START;
        start_address = '0;
        byte_count = '0;
        flash_byte = '0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        stall_req_cnt = 0;
        items_taken = 0;
        useful_items = 0;
        reads_started = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: events while idle are dropped
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
        send_item(OP_UNUSED, 32'h5555_5555, 24'hAA_AAAA, 8'h5A);

        // zero count: enable then disable, block stays idle
        send_item(OP_START, 32'hFFFF_FFFF, 24'h0, 8'h00);
        wait_drain;

        // address wrap: two bytes before 2^32, wrap to 0 is a page boundary
        send_item(OP_START, 32'hFFFF_FFFE, 24'd4, 8'h00);
        send_item(OP_START, 32'h1234_5678, 24'd9, 8'h11);   // start while busy
        send_item(OP_DATA, 32'h0, 24'h0, 8'h22);            // data while waiting
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);           // ready while reading
        send_item(OP_DATA, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'hFF);
        send_item(OP_UNUSED, 32'h0, 24'h0, 8'h33);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'hA5);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h5A);
        wait_drain;

        // plain page crossing mid read
        send_item(OP_START, 32'h0000_07FE, 24'd3, 8'h00);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h01);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h80);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h7F);

        // single byte from address zero
        send_item(OP_START, 32'h0, 24'd1, 8'h00);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'hFF);
        wait_drain;

        // random reads, mostly well formed with some dropped items
        useful_items = 0;
        seq_idx = 0;
        while (items_taken < RANDOM_ITEMS)
        begin
            // a long stretch with no idling on either side; no sender idling in the stall read
            in_idle_on <= !(seq_idx >= 12 && seq_idx < 24) && (seq_idx != 6);
            out_idle_on <= !(seq_idx >= 12 && seq_idx < 24);
            if (seq_idx == 6)
            begin
                // receiver holds off while the sender keeps offering a dense read
                stall_req_cnt <= stall_req_cnt + 1;
                read_sequence(32'h0000_0FFA, 24'd12, 0);
            end
            else
                random_read(15);
            if ((seq_idx % 9) == 4)
                wait_drain;
            seq_idx++;
        end

        // largest byte count from the last byte of flash; never finishes, which is fine
        wait_drain;
        in_idle_on <= 1'b1;
        out_idle_on <= 1'b1;
        send_item(OP_START, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h00);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h3C);
        send_item(OP_READY, 32'h0, 24'h0, 8'h00);
        send_item(OP_DATA, 32'h0, 24'h0, 8'hC3);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h96);
        send_item(OP_DATA, 32'h0, 24'h0, 8'h69);

        // drain, then let the block settle
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("summary: %0d input items taken (%0d in random reads), %0d reads started, %0d results checked",
                 items_taken, useful_items, reads_started, results_checked);
        $display("summary: zero counts, page crossings, address wrap, dropped events, long stall");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
